### hdl/tiex_pkg.sv
// Shared types and constants for the tiny 8-bit instruction executor.
// Used by the execute core and the top level; depends on nothing else.
package tiex_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned INSTR_W = 8;
    localparam int unsigned REG_COUNT = 4;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned SKIP_W = 2;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [INSTR_W-1:0] instr_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [SKIP_W-1:0] skip_t;

    typedef enum logic [1:0] {
        OP_MISC = 2'b00,
        OP_ADD  = 2'b01,
        OP_SUB  = 2'b10,
        OP_LOAD = 2'b11
    } opcode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     show_decimal;
        logic                     show_hex;
        logic                     show_char;
    } result_t;

endpackage

### hdl/tiex_exec.sv
// Execute core: register file, skip counter and the combinational ALU.
// Depends on tiex_pkg.
module tiex_exec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  tiex_pkg::instr_t instr,
    output logic            emit,
    output tiex_pkg::result_t result
);
    import tiex_pkg::*;

    data_t    regs_reg [REG_COUNT];
    data_t    regs_next [REG_COUNT];
    skip_t    skip_reg;
    skip_t    skip_next;

    opcode_t  op;
    reg_idx_t dst;
    reg_idx_t src;
    reg_idx_t trg;
    reg_idx_t sel;
    data_t    src_val;
    data_t    trg_val;
    data_t    imm;
    logic     is_compare;
    logic     skipping;

    assign op         = opcode_t'(instr[7:6]);
    assign dst        = instr[5:4];
    assign src        = instr[3:2];
    assign trg        = instr[1:0];
    assign sel        = instr[4:3];
    assign src_val    = regs_reg[src];
    assign trg_val    = regs_reg[trg];
    assign imm        = {{(DATA_W-4){instr[3]}}, instr[3:0]};
    assign is_compare = instr[5];
    assign skipping   = (skip_reg != '0);

    // A print emits only when it is not skipped and requests at least one format.
    assign emit = !skipping && (op == OP_MISC) && !is_compare && (|instr[2:0]);

    always_comb
    begin
        result.value        = regs_reg[sel];
        result.show_decimal = instr[2];
        result.show_hex     = instr[1];
        result.show_char    = instr[0];
    end

    always_comb
    begin
        regs_next = regs_reg;
        skip_next = skip_reg;
        if (skipping)
        begin
            skip_next = skip_reg - 2'd1;
        end
        else
        begin
            unique case (op)
                OP_ADD:  regs_next[dst] = src_val + trg_val;
                OP_SUB:  regs_next[dst] = src_val - trg_val;
                OP_LOAD: regs_next[dst] = imm;
                OP_MISC:
                begin
                    if (is_compare && (src_val == trg_val))
                    begin
                        skip_next = {1'b0, instr[4]} + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
            skip_reg <= '0;
        end
        else if (fire)
        begin
            regs_reg <= regs_next;
            skip_reg <= skip_next;
        end
    end

endmodule

### hdl/tiny_isa_executor_8bit_unit.sv
// Top level of the tiny 8-bit instruction executor: input register, execute core
// and output register. Depends on tiex_pkg and tiex_exec.
//
// Usage:
//   Input channel: in_valid, in_stall, instruction. One instruction per transaction.
//   Output channel: out_valid, out_stall, print_value and the three show flags.
//   Only a print that is not skipped and has a format flag set produces an output
//   transaction; every other instruction updates state silently.
// Flow: an accepted instruction waits in the input register; the execute core
//   works on the input register and, for a print that emits, writes the
//   output register as the instruction leaves it.
// Throughput: one instruction per cycle while no print waits on a blocked output.
//   The register file and skip counter are read and written in the same execute
//   cycle, so consecutive instructions see each other's results without any wait.
// Stalls: while out_stall is high and a result is held, an instruction that would
//   print waits in the input register and in_stall rises; instructions that
//   produce no result still flow through.
// Reset: rst_n clears the four registers, the skip counter and both valid bits.
module tiny_isa_executor_8bit_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           instruction,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [7:0]    print_value,
    output logic                 show_decimal,
    output logic                 show_hex,
    output logic                 show_char
);
    import tiex_pkg::*;

    logic    in_valid_reg;
    instr_t  instr_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t exec_result;
    logic    exec_emit;
    logic    advance;
    logic    accept;

    // The held item leaves unless it would print into a blocked output register.
    assign advance  = in_valid_reg && !(exec_emit && out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    tiex_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .instr  (instr_reg),
        .emit   (exec_emit),
        .result (exec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= instruction;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && exec_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && exec_emit)
        begin
            result_reg <= exec_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign print_value  = result_reg.value;
    assign show_decimal = result_reg.show_decimal;
    assign show_hex     = result_reg.show_hex;
    assign show_char    = result_reg.show_char;

endmodule

### hdl/tiex_checker.sv
// Port-level checks for the tiny 8-bit instruction executor, bound to the top level.
// Depends only on the top-level ports.
module tiex_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] instruction,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] print_value,
    input logic       show_decimal,
    input logic       show_hex,
    input logic       show_char
);

    // A held output transaction keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(print_value)
            && $stable(show_decimal) && $stable(show_hex) && $stable(show_char))
        else $error("output payload changed while stalled");

    // Every result requests at least one display format.
    a_flag_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (show_decimal || show_hex || show_char))
        else $error("result without any display flag");

    // The input side stalls only behind a blocked output transaction.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output");

    // A fresh result comes from an accepted instruction, through the input and output registers.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result appeared without an accepted instruction");

    // A stalled input transaction stays offered with the same instruction.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(instruction))
        else $error("input transaction changed while stalled");

endmodule

bind tiny_isa_executor_8bit_unit tiex_checker u_tiex_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .instruction  (instruction),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .print_value  (print_value),
    .show_decimal (show_decimal),
    .show_hex     (show_hex),
    .show_char    (show_char)
);

### tb/tiny_isa_executor_8bit_unit_tb.sv
// Self-checking testbench for tiny_isa_executor_8bit_unit: directed and random programs,
// random idling on both channels. Depends on tiex_pkg and the executor RTL.
module tiny_isa_executor_8bit_unit_tb;

    import tiex_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    instr_t            instruction = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [7:0] print_value;
    logic              show_decimal;
    logic              show_hex;
    logic              show_char;

    // Shadow of the architectural state and the prints still owed by the block.
    data_t   reg_shadow [REG_COUNT];
    skip_t   skip_left;
    result_t pending_prints [$];
    int      failures;
    bit      quiet_mode;

    tiny_isa_executor_8bit_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .instruction  (instruction),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .print_value  (print_value),
        .show_decimal (show_decimal),
        .show_hex     (show_hex),
        .show_char    (show_char)
    );

    always #5 clk = ~clk;

    function automatic instr_t alu_word(opcode_t op, reg_idx_t d, reg_idx_t s, reg_idx_t t);
        return {op, d, s, t};
    endfunction

    function automatic instr_t load_word(reg_idx_t d, logic [3:0] imm);
        return {OP_LOAD, d, imm};
    endfunction

    function automatic instr_t compare_word(logic skip_two, reg_idx_t a, reg_idx_t b);
        return {OP_MISC, 1'b1, skip_two, a, b};
    endfunction

    function automatic instr_t print_word(reg_idx_t sel, logic dec, logic hex, logic chr);
        return {OP_MISC, 1'b0, sel, dec, hex, chr};
    endfunction

    function automatic int draw_wait();
        if (quiet_mode)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // Applies one accepted instruction to the shadow state and queues any print it makes.
    function automatic void execute_instruction(instr_t ins);
        reg_idx_t dst;
        reg_idx_t src;
        reg_idx_t trg;
        result_t  res;
        dst = ins[5:4];
        src = ins[3:2];
        trg = ins[1:0];
        if (skip_left != 0)
        begin
            skip_left = skip_left - 2'd1;
            return;
        end
        case (opcode_t'(ins[7:6]))
            OP_ADD:  reg_shadow[dst] = reg_shadow[src] + reg_shadow[trg];
            OP_SUB:  reg_shadow[dst] = reg_shadow[src] - reg_shadow[trg];
            OP_LOAD: reg_shadow[dst] = {{4{ins[3]}}, ins[3:0]};
            OP_MISC:
            begin
                if (ins[5])
                begin
                    if (reg_shadow[src] == reg_shadow[trg])
                        skip_left = {1'b0, ins[4]} + 2'd1;
                end
                else if (ins[2:0] != 3'b000)
                begin
                    res.value = reg_shadow[ins[4:3]];
                    res.show_decimal = ins[2];
                    res.show_hex = ins[1];
                    res.show_char = ins[0];
                    pending_prints.push_back(res);
                end
            end
        endcase
    endfunction

    task automatic send_instruction(instr_t ins);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        instruction <= ins;
        do @(posedge clk); while (in_stall);
        execute_instruction(ins);
    endtask

    task automatic wait_prints_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_prints.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Output side: hold stall for a random wait drawn by draw_wait, then take one transaction.
    initial
    begin
        int hold;
        forever
        begin
            hold = draw_wait();
            @(negedge clk);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_prints.size() == 0)
            begin
                $error("unexpected print transaction, print_value %0d", print_value);
                failures++;
            end
            else
            begin
                want = pending_prints.pop_front();
                if (print_value !== want.value)
                begin
                    $error("print_value: expected %0d, actual %0d", want.value, print_value);
                    failures++;
                end
                if (show_decimal !== want.show_decimal)
                begin
                    $error("show_decimal: expected %0b, actual %0b",
                           want.show_decimal, show_decimal);
                    failures++;
                end
                if (show_hex !== want.show_hex)
                begin
                    $error("show_hex: expected %0b, actual %0b", want.show_hex, show_hex);
                    failures++;
                end
                if (show_char !== want.show_char)
                begin
                    $error("show_char: expected %0b, actual %0b", want.show_char, show_char);
                    failures++;
                end
            end
        end
    end

    // Loads of the immediate extremes, -1 and zero, then prints with each single flag and none.
    task automatic test_load_and_print();
        send_instruction(load_word(2'd0, 4'h7));
        send_instruction(load_word(2'd1, 4'h8));
        send_instruction(load_word(2'd2, 4'hF));
        send_instruction(load_word(2'd3, 4'h0));
        send_instruction(print_word(2'd0, 1'b1, 1'b0, 1'b0));
        send_instruction(print_word(2'd1, 1'b0, 1'b1, 1'b0));
        send_instruction(print_word(2'd2, 1'b0, 1'b0, 1'b1));
        send_instruction(print_word(2'd3, 1'b0, 1'b0, 1'b0));
    endtask

    // Doubling -8 reaches -128; one more add and a subtract both wrap around.
    task automatic test_arith_wrap();
        repeat (4) send_instruction(alu_word(OP_ADD, 2'd1, 2'd1, 2'd1));
        send_instruction(alu_word(OP_ADD, 2'd2, 2'd1, 2'd1));
        send_instruction(alu_word(OP_SUB, 2'd3, 2'd0, 2'd1));
        send_instruction(print_word(2'd1, 1'b1, 1'b1, 1'b1));
        send_instruction(print_word(2'd2, 1'b1, 1'b0, 1'b0));
        send_instruction(print_word(2'd3, 1'b0, 1'b1, 1'b1));
    endtask

    // Equal compares skip one or two instructions, skipped prints stay silent,
    // and an unequal compare skips nothing.
    task automatic test_skip();
        send_instruction(compare_word(1'b0, 2'd0, 2'd0));
        send_instruction(print_word(2'd0, 1'b1, 1'b1, 1'b1));
        send_instruction(print_word(2'd0, 1'b0, 1'b1, 1'b0));
        send_instruction(compare_word(1'b1, 2'd2, 2'd2));
        send_instruction(alu_word(OP_ADD, 2'd0, 2'd0, 2'd0));
        send_instruction(print_word(2'd3, 1'b1, 1'b1, 1'b1));
        send_instruction(compare_word(1'b1, 2'd0, 2'd1));
        send_instruction(print_word(2'd0, 1'b1, 1'b0, 1'b1));
        wait_prints_drained();
    endtask

    task automatic test_random_mix(int count);
        int       pick;
        reg_idx_t a;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            a = reg_idx_t'($urandom_range(0, 3));
            if (pick < 5)
                send_instruction(instr_t'($urandom_range(0, 255)));
            else if (pick < 7)
                send_instruction(print_word(a, 1'($urandom), 1'($urandom), 1'($urandom)));
            else if (pick < 8)
                send_instruction(compare_word(1'($urandom), a,
                    $urandom_range(0, 1) ? a : reg_idx_t'($urandom_range(0, 3))));
            else
                send_instruction(load_word(a, 4'($urandom_range(0, 3))));
        end
    endtask

    task automatic test_back_to_back(int count);
        quiet_mode = 1'b1;
        test_random_mix(count);
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        for (int r = 0; r < REG_COUNT; r++)
            reg_shadow[r] = '0;
        skip_left = '0;
        failures = 0;
        quiet_mode = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_load_and_print();
        test_arith_wrap();
        test_skip();
        test_random_mix(600);
        test_back_to_back(250);
        test_random_mix(600);

        wait_prints_drained();
        if (failures == 0 && pending_prints.size() == 0)
            $display("tiny_isa_executor_8bit_unit_tb passed");
        else
            $display("tiny_isa_executor_8bit_unit_tb failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tiny_isa_executor_8bit_unit_tb failed");
        $finish;
    end

endmodule

### sim.f
hdl/tiex_pkg.sv
hdl/tiex_exec.sv
hdl/tiny_isa_executor_8bit_unit.sv
hdl/tiex_checker.sv
tb/tiny_isa_executor_8bit_unit_tb.sv
